FILE: sv/lpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefix deframer package
// Shared types, widths and codes of the deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Header bytes per message; header bytes beyond LEN_BYTES are consumed and ignored
  localparam int HEADER_BYTES = 4;
  localparam int HCNT_W       = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int LEN_W        = 32;
  localparam int LEN_BYTES    = LEN_W / 8;

  typedef logic [HCNT_W-1:0] hcnt_t;
  typedef logic [HCNT_W:0]   hcnt_ext_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam hcnt_ext_t HDR_END     = hcnt_ext_t'(HEADER_BYTES);
  localparam len_t      MAX_LEN_RST = len_t'(65536);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       first;
    logic       last;
    len_t       length;
  } res_t;

endpackage

FILE: sv/lpd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, data_byte, chunk_last, input ready);
  modport sink   (input valid, data_byte, chunk_last, output ready);
endinterface

interface lpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        message_first;
  logic        message_last;
  logic [31:0] message_length;

  modport source (output valid, result_kind, payload_byte, message_first,
                  message_last, message_length, input ready);
  modport sink   (input valid, result_kind, payload_byte, message_first,
                  message_last, message_length, output ready);
endinterface

FILE: sv/length_prefix_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefix deframer
// Splits a byte stream into messages framed by a little-endian length header.
// ----------------------------------------------------------------------------
// Usage:
//   stream  - byte beats in: data_byte plus chunk_last, marking the last byte
//             of a received chunk. A beat moves when valid and ready are high.
//   result  - one beat per payload byte (kind payload, first/last flags and
//             the message length), one beat per zero-length header (kind
//             empty) and one beat per oversized header (kind error, with the
//             rejected length). Header bytes and discarded bytes give none.
//   cfg_we / cfg_wdata - write max_message_length (reset 65536); write only
//             while the block is idle.
// Path: an accepted byte lands in the input register; the framing step then
//   loads its result into the output register once that register is free.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   combinational framing update between the input and output registers.
// Reset: framing returns to header collection, both registers empty, and the
//   length limit goes back to 65536.
// Stall: a result held in the output register stops the framing step; the
//   input register then fills and stream.ready drops until result.ready.
// ----------------------------------------------------------------------------
module length_prefix_deframer
  import lpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  lpd_byte_if.sink            stream,
  lpd_result_if.source        result,
  input  logic                cfg_we,
  input  logic [LEN_W-1:0]    cfg_wdata
);

  len_t       max_message_length;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Output register
  logic       out_valid;
  kind_t      out_kind;
  logic [7:0] out_byte;
  logic       out_first;
  logic       out_last;
  len_t       out_length;

  res_t       res;
  logic       advance;

  // Advance the framing step when a byte waits and the output slot is free
  // or is being drained in this cycle.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_message_length <= cfg_wdata;
    end
  end

  // Hold the beat until the framing step consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
      in_last <= stream.chunk_last;
    end
  end

  lpd_frame_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .chunk_last (in_last),
    .max_len    (max_message_length),
    .res        (res)
  );

  // Load a result on each step; drop the valid once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind   <= res.kind;
      out_byte   <= res.payload_byte;
      out_first  <= res.first;
      out_last   <= res.last;
      out_length <= res.length;
    end
  end

  assign result.valid          = out_valid;
  assign result.result_kind    = out_kind;
  assign result.payload_byte   = out_byte;
  assign result.message_first  = out_first;
  assign result.message_last   = out_last;
  assign result.message_length = out_length;

  // A byte that waits while the output stalls must stay in place
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input register lost or changed a waiting byte");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> in_valid && out_valid && !result.ready)
    else $error("stream stalled without a blocked result");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_PAYLOAD || out_kind == KIND_EMPTY ||
                   out_kind == KIND_ERROR))
    else $error("unknown result kind");

  a_error_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERROR |->
      !out_first && !out_last && out_byte == 8'd0 && out_length != '0)
    else $error("malformed length error result");

  a_empty_msg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_EMPTY |->
      out_last && !out_first && out_length == '0 && out_byte == 8'd0)
    else $error("malformed empty message result");

endmodule

FILE: sv/lpd_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer framing state machine
// Header collection, payload counting and discard; one byte per step.
// ----------------------------------------------------------------------------
module lpd_frame_fsm
  import lpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       chunk_last,
  input  len_t       max_len,
  output res_t       res
);

  phase_t phase, phase_next;
  hcnt_t  header_count, header_count_next;
  len_t   header_value, header_value_next;
  len_t   bytes_left, bytes_left_next;
  len_t   current_length, current_length_next;

  len_t      hdr_assembled;
  hcnt_ext_t hdr_count_inc;
  logic      hdr_done;
  logic      len_too_big;
  logic      len_zero;
  logic      pay_first;
  logic      pay_fin;

  // Insert the byte into its lane of the length word
  always_comb begin
    hdr_assembled = header_value;
    for (int i = 0; i < LEN_BYTES; i++) begin
      if ({1'b0, header_count} == hcnt_ext_t'(i)) begin
        hdr_assembled[8*i +: 8] = header_value[8*i +: 8] | data_byte;
      end
    end
  end

  assign hdr_count_inc = {1'b0, header_count} + hcnt_ext_t'(1);
  assign hdr_done      = (hdr_count_inc >= HDR_END);
  assign len_too_big   = (hdr_assembled > max_len);
  assign len_zero      = (hdr_assembled == '0);
  assign pay_first     = (bytes_left == current_length);
  assign pay_fin       = (bytes_left <= len_t'(1));

  // Next state
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    header_value_next   = header_value;
    bytes_left_next     = bytes_left;
    current_length_next = current_length;
    case (phase)
      PH_PAYLOAD: begin
        if (pay_fin) begin
          bytes_left_next = '0;
          phase_next      = PH_HEADER;
        end else begin
          bytes_left_next = bytes_left - len_t'(1);
        end
      end
      PH_DISCARD: begin
        if (chunk_last) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        if (!hdr_done) begin
          header_count_next = hdr_count_inc[HCNT_W-1:0];
          header_value_next = hdr_assembled;
        end else begin
          header_count_next = '0;
          header_value_next = '0;
          if (len_too_big) begin
            phase_next = chunk_last ? PH_HEADER : PH_DISCARD;
          end else if (len_zero) begin
            current_length_next = '0;
          end else begin
            current_length_next = hdr_assembled;
            bytes_left_next     = hdr_assembled;
            phase_next          = PH_PAYLOAD;
          end
        end
      end
    endcase
  end

  // Result for this byte
  always_comb begin
    res = '{valid: 1'b0, kind: KIND_PAYLOAD, payload_byte: 8'd0, first: 1'b0,
            last: 1'b0, length: '0};
    case (phase)
      PH_PAYLOAD: begin
        res.valid        = 1'b1;
        res.payload_byte = data_byte;
        res.first        = pay_first;
        res.last         = pay_fin;
        res.length       = current_length;
      end
      PH_DISCARD: begin
        res.valid = 1'b0;
      end
      default: begin
        if (hdr_done) begin
          if (len_too_big) begin
            res.valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.length = hdr_assembled;
          end else if (len_zero) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      header_value   <= '0;
      bytes_left     <= '0;
      current_length <= '0;
    end else if (step) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      header_value   <= header_value_next;
      bytes_left     <= bytes_left_next;
      current_length <= current_length_next;
    end
  end

endmodule
